// File: src/lkvc_pkg.sv
// Shared types and constants for the LRU key/value cache.
package lkvc_pkg;

  localparam int KIND_W      = 8;
  localparam int KEY_MAX_W   = 64;
  localparam int HANDLE_W    = 64;
  localparam int CAP_W       = 5;
  localparam int APB_DATA_W  = 32;
  localparam int APB_ADDR_W  = 3;
  localparam int QUEUE_PTR_W = 1;
  localparam int QUEUE_DEPTH = 1 << QUEUE_PTR_W;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic OPC_LOOKUP = 1'b0;
  localparam logic OPC_STORE  = 1'b1;

  localparam logic [0:0] REG_CAPACITY = 1'b0;

  localparam logic [1:0] CLS_LOOKUP = 2'd0;
  localparam logic [1:0] CLS_STORE  = 2'd1;
  localparam logic [1:0] CLS_REJECT = 2'd2;

  typedef struct packed {
    logic [1:0]           cls;
    logic [KIND_W-1:0]    key_kind;
    logic [KEY_MAX_W-1:0] key_bits;
    logic [HANDLE_W-1:0]  data_handle;
  } work_t;

  typedef struct packed {
    logic                hit;
    logic [HANDLE_W-1:0] data_out;
    logic                evicted;
    logic                rejected;
  } result_t;

endpackage

// File: src/lkvc_req_if.sv
// Request channel: lookup or store request into the cache.
interface lkvc_req_if;
  logic                           valid;
  logic                           ready;
  logic                           opcode;
  logic [lkvc_pkg::KIND_W-1:0]    key_kind;
  logic [lkvc_pkg::KEY_MAX_W-1:0] key_bits;
  logic [lkvc_pkg::HANDLE_W-1:0]  data_handle;

  modport source (output valid, opcode, key_kind, key_bits, data_handle, input ready);
  modport sink   (input valid, opcode, key_kind, key_bits, data_handle, output ready);
endinterface

// File: src/lkvc_rsp_if.sv
// Result channel: one result per cache request.
interface lkvc_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          hit;
  logic [lkvc_pkg::HANDLE_W-1:0] data_out;
  logic                          evicted;
  logic                          rejected;

  modport source (output valid, hit, data_out, evicted, rejected, input ready);
  modport sink   (input valid, hit, data_out, evicted, rejected, output ready);
endinterface

// File: src/lkvc_front.sv
// Front end: accepts requests, masks the key and classifies the operation.
module lkvc_front #(
  parameter int KEY_WIDTH = 64
) (
  lkvc_req_if.sink         req,
  output logic             push_valid,
  input  logic             push_ready,
  output lkvc_pkg::work_t  push_data
);

  localparam logic [lkvc_pkg::KEY_MAX_W-1:0] KEY_MASK =
    {lkvc_pkg::KEY_MAX_W{1'b1}} >> (lkvc_pkg::KEY_MAX_W - KEY_WIDTH);

  assign req.ready  = push_ready;
  assign push_valid = req.valid;

  always_comb begin
    push_data.key_kind    = req.key_kind;
    push_data.key_bits    = req.key_bits & KEY_MASK;
    push_data.data_handle = req.data_handle;
    if (req.opcode == lkvc_pkg::OPC_LOOKUP) begin
      push_data.cls = lkvc_pkg::CLS_LOOKUP;
    end else if (req.data_handle == '0) begin
      push_data.cls = lkvc_pkg::CLS_REJECT;
    end else begin
      push_data.cls = lkvc_pkg::CLS_STORE;
    end
  end

endmodule

// File: src/lkvc_queue.sv
// Short request queue between the front end and the execute stage.
module lkvc_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  lkvc_pkg::work_t  push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output lkvc_pkg::work_t  pop_data
);

  lkvc_pkg::work_t                   mem_r [lkvc_pkg::QUEUE_DEPTH];
  logic [lkvc_pkg::QUEUE_PTR_W-1:0]  wr_ptr_r;
  logic [lkvc_pkg::QUEUE_PTR_W-1:0]  rd_ptr_r;
  logic [lkvc_pkg::QUEUE_PTR_W:0]    count_r;
  logic                              push;
  logic                              pop;

  assign push_ready = (count_r != (lkvc_pkg::QUEUE_PTR_W+1)'(lkvc_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: src/lkvc_back.sv
// Execute stage: parallel match, LRU rank update, insert/evict and result register.
module lkvc_back #(
  parameter int ENTRIES   = 16,
  parameter int KEY_WIDTH = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic [$clog2(ENTRIES+1)-1:0]       cap_eff,
  input  logic                               pop_valid,
  output logic                               pop_ready,
  input  lkvc_pkg::work_t                    pop_data,
  lkvc_rsp_if.source                         rsp,
  output logic [$clog2(ENTRIES+1)-1:0]       occupancy
);

  localparam int IDX_W  = $clog2(ENTRIES);
  localparam int RANK_W = IDX_W;
  localparam int CNT_W  = $clog2(ENTRIES+1);

  logic [ENTRIES-1:0]                 valid_r;
  logic [ENTRIES-1:0]                 valid_nxt;
  logic [lkvc_pkg::KIND_W-1:0]        kind_r   [ENTRIES];
  logic [KEY_WIDTH-1:0]               key_r    [ENTRIES];
  logic [lkvc_pkg::HANDLE_W-1:0]      handle_r [ENTRIES];
  logic [RANK_W-1:0]                  rank_r   [ENTRIES];
  logic [RANK_W-1:0]                  rank_nxt [ENTRIES];
  logic [CNT_W-1:0]                   count_r;
  logic [CNT_W-1:0]                   count_nxt;
  logic                               out_valid_r;
  lkvc_pkg::result_t                  out_r;
  lkvc_pkg::result_t                  res_nxt;

  logic                               exec;
  logic [ENTRIES-1:0]                 match;
  logic [ENTRIES-1:0]                 victim;
  logic [ENTRIES-1:0]                 valid_after;
  logic                               hit_any;
  logic [IDX_W-1:0]                   hit_idx;
  logic [RANK_W-1:0]                  old_rank;
  logic [RANK_W-1:0]                  last_rank;
  logic                               need_evict;
  logic                               free_found;
  logic [IDX_W-1:0]                   free_idx;

  assign pop_ready = !out_valid_r || rsp.ready;
  assign exec      = pop_valid && pop_ready;
  assign occupancy = count_r;

  assign rsp.valid    = out_valid_r;
  assign rsp.hit      = out_r.hit;
  assign rsp.data_out = out_r.data_out;
  assign rsp.evicted  = out_r.evicted;
  assign rsp.rejected = out_r.rejected;

  assign last_rank  = RANK_W'(count_r - CNT_W'(1));
  assign need_evict = (count_r >= cap_eff);
  assign old_rank   = rank_r[hit_idx];

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match[i]  = valid_r[i] && (kind_r[i] == pop_data.key_kind) &&
                  (key_r[i] == pop_data.key_bits[KEY_WIDTH-1:0]);
      victim[i] = valid_r[i] && (rank_r[i] == last_rank);
    end
    valid_after = need_evict ? (valid_r & ~victim) : valid_r;
    hit_any     = |match;
    hit_idx     = '0;
    free_found  = 1'b0;
    free_idx    = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_idx = IDX_W'(i);
      end
      if (!valid_after[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    count_nxt = count_r;
    rank_nxt  = rank_r;
    res_nxt   = '0;
    if (exec) begin
      case (pop_data.cls)
        lkvc_pkg::CLS_LOOKUP, lkvc_pkg::CLS_STORE: begin
          if (hit_any) begin
            res_nxt.hit = 1'b1;
            if (pop_data.cls == lkvc_pkg::CLS_LOOKUP) begin
              res_nxt.data_out = handle_r[hit_idx];
            end
            for (int i = 0; i < ENTRIES; i++) begin
              if (valid_r[i] && (rank_r[i] < old_rank)) begin
                rank_nxt[i] = rank_r[i] + 1'b1;
              end
            end
            rank_nxt[hit_idx] = '0;
          end else if ((pop_data.cls == lkvc_pkg::CLS_STORE) && free_found) begin
            res_nxt.evicted = need_evict;
            for (int i = 0; i < ENTRIES; i++) begin
              if (valid_after[i]) begin
                rank_nxt[i] = rank_r[i] + 1'b1;
              end
            end
            valid_nxt           = valid_after;
            valid_nxt[free_idx] = 1'b1;
            rank_nxt[free_idx]  = '0;
            count_nxt           = need_evict ? count_r : count_r + 1'b1;
          end
        end
        lkvc_pkg::CLS_REJECT: begin
          res_nxt.rejected = 1'b1;
        end
        default: begin
          res_nxt = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_r[i] <= '0;
      end
    end else begin
      valid_r <= valid_nxt;
      count_r <= count_nxt;
      rank_r  <= rank_nxt;
      if (exec) begin
        out_valid_r <= 1'b1;
      end else if (rsp.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      out_r <= res_nxt;
    end
    if (exec && (pop_data.cls == lkvc_pkg::CLS_STORE)) begin
      if (hit_any) begin
        handle_r[hit_idx] <= pop_data.data_handle;
      end else if (free_found) begin
        kind_r[free_idx]   <= pop_data.key_kind;
        key_r[free_idx]    <= pop_data.key_bits[KEY_WIDTH-1:0];
        handle_r[free_idx] <= pop_data.data_handle;
      end
    end
  end

endmodule

// File: src/lru_key_value_cache_core.sv
// Top level of the fully associative LRU key/value cache.
// A request is written into the queue, then executed and held in the result register.
// Throughput: one request per cycle while results are taken; the execute stage matches and
// updates all flop-held entries at once; a stalled result side fills the 2-deep queue.
// Reset: all entries invalid, capacity register 16 (clamped to ENTRIES); no clearing pass.
module lru_key_value_cache_core #(
  parameter int ENTRIES   = 16,
  parameter int KEY_WIDTH = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  lkvc_req_if.sink                          in_req,
  lkvc_rsp_if.source                        out_rsp,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [lkvc_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [lkvc_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [lkvc_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready
);

  localparam int CNT_W = $clog2(ENTRIES+1);
  localparam int CMP_W = (CNT_W > lkvc_pkg::CAP_W) ? CNT_W : lkvc_pkg::CAP_W;

  logic [lkvc_pkg::CAP_W-1:0] cap_r;
  logic [CMP_W-1:0]           cap_wide;
  logic [CNT_W-1:0]           cap_eff;
  logic [CNT_W-1:0]           occupancy;
  logic [0:0]                 reg_idx;
  logic                       cfg_write;

  logic                       push_valid;
  logic                       push_ready;
  lkvc_pkg::work_t            push_data;
  logic                       pop_valid;
  logic                       pop_ready;
  lkvc_pkg::work_t            pop_data;

  assign pready    = 1'b1;
  assign reg_idx   = paddr[2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= lkvc_pkg::CAP_RESET;
    end else if (cfg_write && (reg_idx == lkvc_pkg::REG_CAPACITY)) begin
      cap_r <= pwdata[lkvc_pkg::CAP_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == lkvc_pkg::REG_CAPACITY) begin
      prdata = lkvc_pkg::APB_DATA_W'(cap_r);
    end
  end

  always_comb begin
    cap_wide = CMP_W'(cap_r);
    if (cap_wide == '0) begin
      cap_eff = CNT_W'(1);
    end else if (cap_wide > CMP_W'(ENTRIES)) begin
      cap_eff = CNT_W'(ENTRIES);
    end else begin
      cap_eff = CNT_W'(cap_wide);
    end
  end

  lkvc_front #(
    .KEY_WIDTH (KEY_WIDTH)
  ) u_front (
    .req        (in_req),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  lkvc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  lkvc_back #(
    .ENTRIES   (ENTRIES),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cap_eff   (cap_eff),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .rsp       (out_rsp),
    .occupancy (occupancy)
  );

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occupancy <= CNT_W'(ENTRIES))
    else $error("occupancy above entry count");

  a_reject_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_rsp.valid && out_rsp.rejected |-> !out_rsp.hit && !out_rsp.evicted &&
    (out_rsp.data_out == '0))
    else $error("rejected request reported other effects");

  a_evict_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_rsp.valid && out_rsp.evicted |-> !out_rsp.hit && (out_rsp.data_out == '0))
    else $error("eviction reported on a hit");

  a_data_needs_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_rsp.valid && (out_rsp.data_out != '0) |-> out_rsp.hit)
    else $error("data returned without a hit");

endmodule
